/* rtl/core/tfvs_pkg.sv */
// ----------------------------------------------------------------------------
// tfvs_pkg
// Shared constants, codes and arithmetic helpers of the trilinear field
// velocity scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package tfvs_pkg;

   // field widths
   localparam int unsigned SPEED_W    = 24;
   localparam int unsigned FACTOR_W   = 16;
   localparam int unsigned POS_W      = 32;
   localparam int unsigned ADDR_W     = 15;
   localparam int unsigned CNT_W      = 6;
   localparam int unsigned REQ_DATA_W = 176;
   localparam int unsigned RSP_DATA_W = 48;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned PROD_W     = 39;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_INV_HORIZ   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INV_VERT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BAND_LOW    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BAND_HIGH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SHEAR_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_POINTS_X    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_POINTS_Y    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_POINTS_Z    = 3'd7;

   // item kinds
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_POINT = 1'b1;

   // result outcome codes
   localparam logic [2:0] OUT_OUTSIDE = 3'd0;
   localparam logic [2:0] OUT_INTERP  = 3'd1;
   localparam logic [2:0] OUT_EDGE    = 3'd2;
   localparam logic [2:0] OUT_OFFGRID = 3'd3;
   localparam logic [2:0] OUT_LOADED  = 3'd4;
   localparam logic [2:0] OUT_ABOVE   = 3'd5;

   // offset-binary flip of a Q2.14 factor
   localparam logic [FACTOR_W-1:0] FACTOR_FLIP = 16'h8000;

   // saturate a grid point count to 2..top
   function automatic logic [8:0] cnt_clamp(input logic [CNT_W-1:0] v, input int unsigned top);
      logic [31:0] v32;
      v32 = 32'(v);
      if (v32 < 32'd2) return 9'd2;
      if (v32 > top) return 9'(top);
      return 9'(v32);
   endfunction

   // one linear step on offset-binary factors, Q0.16 weight
   function automatic logic [15:0] lerp_fn(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] w);
      logic [33:0] acc;
      acc = 34'(a) * (34'h10000 - 34'(w)) + 34'(b) * 34'(w) + 34'd32768;
      return acc[31:16];
   endfunction

   // round a speed product by 2^-14 and saturate to the speed range
   function automatic logic [SPEED_W-1:0] scale_fn(input logic [PROD_W-1:0] prod,
                                                   input logic zero);
      logic [39:0] r;
      r = 40'(prod) + 40'd8192;
      if (zero) return '0;
      if (|r[39:38]) return '1;
      return r[37:14];
   endfunction

endpackage

`default_nettype wire

/* rtl/core/trilinear_field_velocity_scaler.sv */
// ----------------------------------------------------------------------------
// trilinear_field_velocity_scaler
// Scales shear and pressure speeds by a trilinearly interpolated factor
// taken from a 3D grid held in eight single-port memory banks.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while the skid word is empty and
// returns one result word per input word; each word passes through the
// level registers and then the output word. The grid lives in eight banks
// split by the parity of the x, y and z index, so the eight corners of a
// cell are read in the same cycle, one port per bank; a load word writes
// its bank in the same pipeline stage where points read, so a point always
// sees every load accepted before it. Grid content is undefined until
// loaded, not cleared after reset. The user must write configuration through
// csr_wen/csr_index/csr_wdata only while idle; the block does not enforce it.
`default_nettype none

module trilinear_field_velocity_scaler #(
   parameter int unsigned GRID_X = 32,
   parameter int unsigned GRID_Y = 32,
   parameter int unsigned GRID_Z = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // tdata: load_addr[14:0], load_factor[30:15], pos_x[62:31], pos_y[94:63],
   //        pos_z[126:95], shear_in[150:127], pressure_in[174:151], pad[175]
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [tfvs_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: op[0]
   input  wire logic [0:0]                           req_tuser,
   // tdata: shear_out[23:0], pressure_out[47:24]
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [tfvs_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   // tuser: outcome[2:0]
   output logic [2:0]                                rsp_tuser,
   input  wire logic                                 csr_wen,
   input  wire logic [tfvs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tfvs_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned HX = (GRID_X + 1) / 2;
   localparam int unsigned HY = (GRID_Y + 1) / 2;
   localparam int unsigned HZ = (GRID_Z + 1) / 2;
   localparam int unsigned BANK_DEPTH = HX * HY * HZ;
   localparam int unsigned BAW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int unsigned XW = $clog2(GRID_X);
   localparam int unsigned YW = $clog2(GRID_Y);
   localparam int unsigned ZW = $clog2(GRID_Z);
   localparam int unsigned GRID_WORDS = GRID_X * GRID_Y * GRID_Z;
   localparam int unsigned SW = tfvs_pkg::SPEED_W;
   localparam int unsigned FW = tfvs_pkg::FACTOR_W;
   localparam int unsigned AW = tfvs_pkg::ADDR_W;
   localparam int unsigned PW = tfvs_pkg::PROD_W;
   // reciprocals for exact division of a 15-bit address
   localparam logic [32:0] RECIP_X =
      33'(((64'd1 << 32) + 64'(GRID_X) - 64'd1) / 64'(GRID_X));
   localparam logic [32:0] RECIP_XY =
      33'(((64'd1 << 32) + 64'(GRID_X * GRID_Y) - 64'd1) / 64'(GRID_X * GRID_Y));

   // configuration registers
   logic [31:0]    inv_horiz_ff, inv_vert_ff, band_low_ff, band_high_ff;
   logic [SW-1:0]  shear_limit_ff;
   logic [5:0]     points_x_ff, points_y_ff, points_z_ff;
   logic [8:0]     nx, ny, nz;

   // flow control
   logic           pipe_en;
   logic [7:0]     vld_ff, vld_in;
   logic           push;

   // level 0: accepted word
   logic           l0_op_ff;
   logic [tfvs_pkg::REQ_DATA_W-1:0] l0_data_ff;
   logic [AW-1:0]  l0_addr;
   logic [FW-1:0]  l0_factor;
   logic [31:0]    l0_px, l0_py, l0_pz, l0_dz;
   logic [SW-1:0]  l0_shear, l0_press;
   logic [47:0]    l0_qx_prod, l0_qk_prod;

   // level 1: products
   logic           l1_op_ff, l1_inband_ff, l1_above_ff;
   logic [63:0]    l1_fx_ff, l1_fy_ff, l1_fz_ff;
   logic [AW-1:0]  l1_addr_ff, l1_qx_ff, l1_qk_ff;
   logic [FW-1:0]  l1_factor_ff;
   logic [SW-1:0]  l1_shear_ff, l1_press_ff;

   // level 1 combinational: cell, outcome and bank addresses
   logic [31:0]    ip, jp, kp;
   logic [31:0]    li, lj, lk;
   logic [31:0]    cx, cy, cz;
   logic [31:0]    hx0, hx1, hy0, hy1, hz0, hz1;
   logic [31:0]    hx, hy, hz, a32;
   logic           load_ok;
   logic [2:0]     l2_outcome_in, l2_par_in;
   logic [BAW-1:0] l2_baddr_in [8];
   logic [7:0]     l2_we_in;

   // level 2: memory access
   logic [2:0]     l2_outcome_ff, l2_par_ff;
   logic [SW-1:0]  l2_shear_ff, l2_press_ff;
   logic [15:0]    l2_wi_ff, l2_wj_ff, l2_wk_ff;
   logic [BAW-1:0] l2_baddr_ff [8];
   logic [7:0]     l2_we_ff;
   logic [FW-1:0]  l2_wdata_ff;

   // level 3: bank read data
   logic [FW-1:0]  l3_rd [8];
   logic [2:0]     l3_outcome_ff, l3_par_ff;
   logic [SW-1:0]  l3_shear_ff, l3_press_ff;
   logic [15:0]    l3_wi_ff, l3_wj_ff, l3_wk_ff;
   logic [15:0]    corner [8];
   logic [15:0]    l4_rx_in [4];

   // level 4..7: interpolation and scaling
   logic [15:0]    l4_rx_ff [4];
   logic [15:0]    l4_c0_ff, l4_wj_ff, l4_wk_ff;
   logic [2:0]     l4_outcome_ff;
   logic [SW-1:0]  l4_shear_ff, l4_press_ff;
   logic [15:0]    l5_ry_ff [2];
   logic [15:0]    l5_c0_ff, l5_wk_ff;
   logic [2:0]     l5_outcome_ff;
   logic [SW-1:0]  l5_shear_ff, l5_press_ff;
   logic [15:0]    l6_u_ff, l6_u_in;
   logic [2:0]     l6_outcome_ff;
   logic [SW-1:0]  l6_shear_ff, l6_press_ff;
   logic [PW-1:0]  l7_ps_ff, l7_pp_ff;
   logic           l7_zero_ff;
   logic [2:0]     l7_outcome_ff;
   logic [SW-1:0]  l7_shear_ff, l7_press_ff;

   // result buffer
   logic [SW-1:0]  res_shear_in, res_press_in;
   logic           rsp_vld_ff, skid_vld_ff;
   logic [SW-1:0]  rsp_shear_ff, rsp_press_ff, skid_shear_ff, skid_press_ff;
   logic [2:0]     rsp_outcome_ff, skid_outcome_ff;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_horiz_ff   <= 32'd16777216;
         inv_vert_ff    <= 32'd16777216;
         band_low_ff    <= '0;
         band_high_ff   <= '1;
         shear_limit_ff <= '1;
         points_x_ff    <= 6'd32;
         points_y_ff    <= 6'd32;
         points_z_ff    <= 6'd32;
      end else if (csr_wen) begin
         case (csr_index)
            tfvs_pkg::REG_INV_HORIZ:   inv_horiz_ff   <= csr_wdata;
            tfvs_pkg::REG_INV_VERT:    inv_vert_ff    <= csr_wdata;
            tfvs_pkg::REG_BAND_LOW:    band_low_ff    <= csr_wdata;
            tfvs_pkg::REG_BAND_HIGH:   band_high_ff   <= csr_wdata;
            tfvs_pkg::REG_SHEAR_LIMIT: shear_limit_ff <= csr_wdata[SW-1:0];
            tfvs_pkg::REG_POINTS_X:    points_x_ff    <= csr_wdata[5:0];
            tfvs_pkg::REG_POINTS_Y:    points_y_ff    <= csr_wdata[5:0];
            tfvs_pkg::REG_POINTS_Z:    points_z_ff    <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   assign nx = tfvs_pkg::cnt_clamp(points_x_ff, GRID_X);
   assign ny = tfvs_pkg::cnt_clamp(points_y_ff, GRID_Y);
   assign nz = tfvs_pkg::cnt_clamp(points_z_ff, GRID_Z);

   // advance the whole pipe unless the skid word is occupied
   assign pipe_en    = !skid_vld_ff;
   assign req_tready = pipe_en;
   assign vld_in     = {vld_ff[6:0], req_tvalid};
   assign push       = pipe_en && vld_ff[7];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= vld_in;
      end
   end

   // capture the input word
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         l0_op_ff   <= req_tuser[0];
         l0_data_ff <= req_tdata;
      end
   end

   assign l0_addr   = l0_data_ff[14:0];
   assign l0_factor = l0_data_ff[30:15];
   assign l0_px     = l0_data_ff[62:31];
   assign l0_py     = l0_data_ff[94:63];
   assign l0_pz     = l0_data_ff[126:95];
   assign l0_shear  = l0_data_ff[150:127];
   assign l0_press  = l0_data_ff[174:151];
   assign l0_dz     = l0_pz - band_low_ff;
   assign l0_qx_prod = 48'(l0_addr) * 48'(RECIP_X);
   assign l0_qk_prod = 48'(l0_addr) * 48'(RECIP_XY);

   // map coordinates onto the grid, split the load address
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         l1_op_ff     <= l0_op_ff;
         l1_inband_ff <= !(l0_pz < band_low_ff || l0_pz > band_high_ff);
         l1_above_ff  <= l0_shear > shear_limit_ff;
         l1_fx_ff     <= 64'(l0_px) * 64'(inv_horiz_ff);
         l1_fy_ff     <= 64'(l0_py) * 64'(inv_horiz_ff);
         l1_fz_ff     <= 64'(l0_dz) * 64'(inv_vert_ff);
         l1_addr_ff   <= l0_addr;
         l1_qx_ff     <= l0_qx_prod[46:32];
         l1_qk_ff     <= l0_qk_prod[46:32];
         l1_factor_ff <= l0_factor;
         l1_shear_ff  <= l0_shear;
         l1_press_ff  <= l0_press;
      end
   end

   // classify the point and form the bank addresses
   always_comb begin
      ip = l1_fx_ff[63:32];
      jp = l1_fy_ff[63:32];
      kp = l1_fz_ff[63:32];
      li = 32'(l1_addr_ff) - 32'(l1_qx_ff) * GRID_X;
      lj = 32'(l1_qx_ff) - 32'(l1_qk_ff) * GRID_Y;
      lk = 32'(l1_qk_ff);
      load_ok = 32'(l1_addr_ff) < GRID_WORDS;

      if (l1_op_ff == tfvs_pkg::OP_LOAD) begin
         l2_outcome_in = tfvs_pkg::OUT_LOADED;
      end else if (!l1_inband_ff) begin
         l2_outcome_in = tfvs_pkg::OUT_OUTSIDE;
      end else if (ip >= 32'(nx) || jp >= 32'(ny) || kp >= 32'(nz)) begin
         l2_outcome_in = tfvs_pkg::OUT_OFFGRID;
      end else if (l1_above_ff) begin
         l2_outcome_in = tfvs_pkg::OUT_ABOVE;
      end else if (ip <= 32'(nx - 9'd2) && jp <= 32'(ny - 9'd2) && kp <= 32'(nz - 9'd2)) begin
         l2_outcome_in = tfvs_pkg::OUT_INTERP;
      end else begin
         l2_outcome_in = tfvs_pkg::OUT_EDGE;
      end

      // pick the cell origin and the half index per bank parity
      if (l1_op_ff == tfvs_pkg::OP_LOAD) begin
         cx  = 32'(li[XW-1:0]);
         cy  = 32'(lj[YW-1:0]);
         cz  = 32'(lk[ZW-1:0]);
         hx0 = cx >> 1;
         hy0 = cy >> 1;
         hz0 = cz >> 1;
      end else begin
         cx  = 32'(ip[XW-1:0]);
         cy  = 32'(jp[YW-1:0]);
         cz  = 32'(kp[ZW-1:0]);
         hx0 = (cx + 32'd1) >> 1;
         hy0 = (cy + 32'd1) >> 1;
         hz0 = (cz + 32'd1) >> 1;
      end
      hx1 = cx >> 1;
      hy1 = cy >> 1;
      hz1 = cz >> 1;
      if (hx0 > HX - 1) hx0 = HX - 1;
      if (hy0 > HY - 1) hy0 = HY - 1;
      if (hz0 > HZ - 1) hz0 = HZ - 1;
      if (hx1 > HX - 1) hx1 = HX - 1;
      if (hy1 > HY - 1) hy1 = HY - 1;
      if (hz1 > HZ - 1) hz1 = HZ - 1;
      l2_par_in = {cz[0], cy[0], cx[0]};

      hx = '0;
      hy = '0;
      hz = '0;
      a32 = '0;
      for (int b = 0; b < 8; b++) begin
         hx  = b[0] ? hx1 : hx0;
         hy  = b[1] ? hy1 : hy0;
         hz  = b[2] ? hz1 : hz0;
         a32 = hx + HX * (hy + HY * hz);
         l2_baddr_in[b] = a32[BAW-1:0];
         l2_we_in[b] = vld_ff[1] && (l1_op_ff == tfvs_pkg::OP_LOAD) && load_ok &&
                       (l2_par_in == 3'(b));
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         l2_outcome_ff <= l2_outcome_in;
         l2_par_ff     <= l2_par_in;
         l2_shear_ff   <= l1_shear_ff;
         l2_press_ff   <= l1_press_ff;
         l2_wi_ff      <= l1_fx_ff[31:16];
         l2_wj_ff      <= l1_fy_ff[31:16];
         l2_wk_ff      <= l1_fz_ff[31:16];
         l2_baddr_ff   <= l2_baddr_in;
         l2_we_ff      <= l2_we_in;
         l2_wdata_ff   <= l1_factor_ff;
      end
   end

   // grid banks: write a load word, read all corners of a point
   for (genvar b = 0; b < 8; b++) begin : g_bank
      logic [FW-1:0] mem [BANK_DEPTH];
      logic [FW-1:0] rd_ff;
      always_ff @(posedge clock) begin
         if (pipe_en) begin
            if (vld_ff[2] && l2_we_ff[b]) begin
               mem[l2_baddr_ff[b]] <= l2_wdata_ff;
            end
            rd_ff <= mem[l2_baddr_ff[b]];
         end
      end
      assign l3_rd[b] = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         l3_outcome_ff <= l2_outcome_ff;
         l3_par_ff     <= l2_par_ff;
         l3_shear_ff   <= l2_shear_ff;
         l3_press_ff   <= l2_press_ff;
         l3_wi_ff      <= l2_wi_ff;
         l3_wj_ff      <= l2_wj_ff;
         l3_wk_ff      <= l2_wk_ff;
      end
   end

   // route banks to cell corners and interpolate along x
   always_comb begin
      for (int d = 0; d < 8; d++) begin
         corner[d] = l3_rd[l3_par_ff ^ 3'(d)] ^ tfvs_pkg::FACTOR_FLIP;
      end
      for (int m = 0; m < 4; m++) begin
         l4_rx_in[m] = tfvs_pkg::lerp_fn(corner[2*m], corner[2*m+1], l3_wi_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         l4_rx_ff      <= l4_rx_in;
         l4_c0_ff      <= corner[0];
         l4_wj_ff      <= l3_wj_ff;
         l4_wk_ff      <= l3_wk_ff;
         l4_outcome_ff <= l3_outcome_ff;
         l4_shear_ff   <= l3_shear_ff;
         l4_press_ff   <= l3_press_ff;
      end
   end

   // interpolate along y
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         l5_ry_ff[0]   <= tfvs_pkg::lerp_fn(l4_rx_ff[0], l4_rx_ff[1], l4_wj_ff);
         l5_ry_ff[1]   <= tfvs_pkg::lerp_fn(l4_rx_ff[2], l4_rx_ff[3], l4_wj_ff);
         l5_c0_ff      <= l4_c0_ff;
         l5_wk_ff      <= l4_wk_ff;
         l5_outcome_ff <= l4_outcome_ff;
         l5_shear_ff   <= l4_shear_ff;
         l5_press_ff   <= l4_press_ff;
      end
   end

   // interpolate along z, or take the cell origin value on the top edge
   assign l6_u_in = (l5_outcome_ff == tfvs_pkg::OUT_INTERP) ?
                    tfvs_pkg::lerp_fn(l5_ry_ff[0], l5_ry_ff[1], l5_wk_ff) : l5_c0_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         l6_u_ff       <= l6_u_in;
         l6_outcome_ff <= l5_outcome_ff;
         l6_shear_ff   <= l5_shear_ff;
         l6_press_ff   <= l5_press_ff;
      end
   end

   // multiply both speeds by the signed factor
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         l7_ps_ff      <= PW'(l6_shear_ff) * PW'(l6_u_ff[14:0]);
         l7_pp_ff      <= PW'(l6_press_ff) * PW'(l6_u_ff[14:0]);
         l7_zero_ff    <= !(l6_u_ff[15] && |l6_u_ff[14:0]);
         l7_outcome_ff <= l6_outcome_ff;
         l7_shear_ff   <= l6_shear_ff;
         l7_press_ff   <= l6_press_ff;
      end
   end

   // round, saturate and choose the result speeds
   always_comb begin
      case (l7_outcome_ff)
         tfvs_pkg::OUT_INTERP, tfvs_pkg::OUT_EDGE: begin
            res_shear_in = tfvs_pkg::scale_fn(l7_ps_ff, l7_zero_ff);
            res_press_in = tfvs_pkg::scale_fn(l7_pp_ff, l7_zero_ff);
         end
         tfvs_pkg::OUT_LOADED: begin
            res_shear_in = '0;
            res_press_in = '0;
         end
         default: begin
            res_shear_in = l7_shear_ff;
            res_press_in = l7_press_ff;
         end
      endcase
   end

   // output word with one skid word behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!rsp_vld_ff || rsp_tready) begin
         rsp_vld_ff  <= skid_vld_ff || push;
         skid_vld_ff <= 1'b0;
      end else if (push) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_vld_ff || rsp_tready) begin
         if (skid_vld_ff) begin
            rsp_shear_ff   <= skid_shear_ff;
            rsp_press_ff   <= skid_press_ff;
            rsp_outcome_ff <= skid_outcome_ff;
         end else begin
            rsp_shear_ff   <= res_shear_in;
            rsp_press_ff   <= res_press_in;
            rsp_outcome_ff <= l7_outcome_ff;
         end
      end else if (push) begin
         skid_shear_ff   <= res_shear_in;
         skid_press_ff   <= res_press_in;
         skid_outcome_ff <= l7_outcome_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_press_ff, rsp_shear_ff};
   assign rsp_tuser  = rsp_outcome_ff;

   // a load word writes at most one bank
   a_single_bank_write : assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> $onehot0(l2_we_ff))
      else $error("load word writes more than one grid bank");

   // the skid word is only used behind a held output word
   a_skid_behind_output : assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_vld_ff)
      else $error("skid word occupied while output word is empty");

   // a load result carries zero speeds
   a_load_zero_speeds : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == tfvs_pkg::OUT_LOADED) |-> (rsp_tdata == '0))
      else $error("load result carries nonzero speeds");

endmodule

`default_nettype wire

/* sim/trilinear_field_velocity_scaler_tb.sv */
// ----------------------------------------------------------------------------
// trilinear_field_velocity_scaler_tb
// Drives load and point words into the velocity scaler, and predicts each
// result word with its own fixed-point grid interpolator. It then compares
// every result word field by field, under several register settings and
// idle patterns.
// ----------------------------------------------------------------------------
module trilinear_field_velocity_scaler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STUCK_LIMIT  = 3000;
   localparam int DRAIN_TAIL   = 16;
   localparam int PHASE_WORDS  = 222;
   localparam int LONG_HOLD    = 400;
   localparam int MAX_REPORTS  = 10;
   localparam int IDX_W        = tfvs_pkg::CSR_IDX_W;

   typedef struct {
      logic        op;
      logic [14:0] addr;
      logic [15:0] factor;
      logic [31:0] px, py, pz;
      logic [23:0] shear, pressure;
   } word_type;

   typedef struct {
      logic [23:0] shear, pressure;
      logic [2:0]  outcome;
   } speeds_type;

   typedef struct {
      bit         fixed;
      speeds_type val;
   } typed_type;

   typedef enum {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type        kind;
      word_type            w;
      logic [IDX_W-1:0]    idx;
      logic [31:0]         data;
      bit                  fixed;
      speeds_type          val;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [tfvs_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [tfvs_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic csr_wen = 1'b0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [tfvs_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   trilinear_field_velocity_scaler u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // predictor copy of grid and registers
   logic [15:0] grid_mem [0:32767];
   bit          grid_loaded [0:32767];
   logic [31:0] inv_h = 32'd16777216, inv_v = 32'd16777216;
   logic [31:0] band_lo = 32'd0, band_hi = 32'hFFFF_FFFF;
   logic [23:0] shear_limit = 24'hFF_FFFF;
   logic [5:0]  cnt_x = 6'd32, cnt_y = 6'd32, cnt_z = 6'd32;

   speeds_type speeds_q [$];
   typed_type  typed_q [$];
   row_type    rows [$];
   int      mismatches = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   bit      hold_request = 0;
   int      hold_left = 0;
   int      stuck = 0;
   int      words_sent = 0;

   function automatic int clamp_cnt(logic [5:0] v, int top);
      if (v < 2) return 2;
      if (v > top) return top;
      return int'(v);
   endfunction

   // map a point onto the grid; outcome before any scaling
   function automatic logic [2:0] locate(word_type w, output logic [63:0] ip, jp, kp,
                                         output logic [15:0] wi, wj, wk);
      logic [63:0] fx, fy, fz;
      int nx, ny, nz;
      ip = 0; jp = 0; kp = 0; wi = 0; wj = 0; wk = 0;
      if (w.pz < band_lo || w.pz > band_hi) return tfvs_pkg::OUT_OUTSIDE;
      nx = clamp_cnt(cnt_x, 32);
      ny = clamp_cnt(cnt_y, 32);
      nz = clamp_cnt(cnt_z, 32);
      fx = 64'(w.px) * 64'(inv_h);
      fy = 64'(w.py) * 64'(inv_h);
      fz = 64'(w.pz - band_lo) * 64'(inv_v);
      ip = fx >> 32; jp = fy >> 32; kp = fz >> 32;
      wi = fx[31:16]; wj = fy[31:16]; wk = fz[31:16];
      if (ip >= nx || jp >= ny || kp >= nz) return tfvs_pkg::OUT_OFFGRID;
      if (w.shear > shear_limit) return tfvs_pkg::OUT_ABOVE;
      if (ip <= nx - 2 && jp <= ny - 2 && kp <= nz - 2) return tfvs_pkg::OUT_INTERP;
      return tfvs_pkg::OUT_EDGE;
   endfunction

   function automatic int grid_addr(logic [63:0] i, j, k);
      return int'(i + 32 * (j + 32 * k));
   endfunction

   function automatic logic [63:0] offset_factor(logic [63:0] i, j, k);
      return 64'(grid_mem[grid_addr(i, j, k)] ^ 16'h8000);
   endfunction

   function automatic logic [63:0] blend(logic [63:0] a, b, logic [15:0] w);
      return (a * (64'd65536 - 64'(w)) + b * 64'(w) + 64'd32768) >> 16;
   endfunction

   function automatic logic [23:0] scaled(logic [23:0] speed, logic [63:0] u);
      logic [63:0] p;
      if (u <= 64'd32768) return '0;
      p = (64'(speed) * (u - 64'd32768) + 64'd8192) >> 14;
      return (p > 64'hFF_FFFF) ? 24'hFF_FFFF : p[23:0];
   endfunction

   // expected result word; a load also updates the grid copy
   function automatic speeds_type predict_speeds(word_type w);
      speeds_type r;
      logic [63:0] ip, jp, kp, u, r0, r1;
      logic [63:0] c [2];
      logic [15:0] wi, wj, wk;
      if (w.op == tfvs_pkg::OP_LOAD) begin
         grid_mem[w.addr] = w.factor;
         r.shear = 0; r.pressure = 0; r.outcome = tfvs_pkg::OUT_LOADED;
         return r;
      end
      r.shear = w.shear; r.pressure = w.pressure;
      r.outcome = locate(w, ip, jp, kp, wi, wj, wk);
      if (r.outcome == tfvs_pkg::OUT_INTERP) begin
         for (int dk = 0; dk < 2; dk++) begin
            r0 = blend(offset_factor(ip, jp, kp + dk), offset_factor(ip + 1, jp, kp + dk), wi);
            r1 = blend(offset_factor(ip, jp + 1, kp + dk),
                       offset_factor(ip + 1, jp + 1, kp + dk), wi);
            c[dk] = blend(r0, r1, wj);
         end
         u = blend(c[0], c[1], wk);
      end else if (r.outcome == tfvs_pkg::OUT_EDGE) begin
         u = offset_factor(ip, jp, kp);
      end else begin
         return r;
      end
      r.shear = scaled(w.shear, u);
      r.pressure = scaled(w.pressure, u);
      return r;
   endfunction

   // grid words a point will read under the current registers
   function automatic void words_read(word_type w, ref int q[$]);
      logic [63:0] ip, jp, kp;
      logic [15:0] wi, wj, wk;
      logic [2:0]  oc;
      q.delete();
      oc = locate(w, ip, jp, kp, wi, wj, wk);
      if (oc == tfvs_pkg::OUT_EDGE) q.insert(q.size(), grid_addr(ip, jp, kp));
      if (oc == tfvs_pkg::OUT_INTERP)
         for (int n = 0; n < 8; n++)
            q.insert(q.size(), grid_addr(ip + n[0], jp + n[1], kp + n[2]));
   endfunction

   function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
         tfvs_pkg::REG_INV_HORIZ:   inv_h = v;
         tfvs_pkg::REG_INV_VERT:    inv_v = v;
         tfvs_pkg::REG_BAND_LOW:    band_lo = v;
         tfvs_pkg::REG_BAND_HIGH:   band_hi = v;
         tfvs_pkg::REG_SHEAR_LIMIT: shear_limit = v[23:0];
         tfvs_pkg::REG_POINTS_X:    cnt_x = v[5:0];
         tfvs_pkg::REG_POINTS_Y:    cnt_y = v[5:0];
         default:                   cnt_z = v[5:0];
      endcase
   endfunction

   function automatic logic [15:0] rand_factor();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2, 3: return 16'(16384 + $urandom_range(0, 4096) - 2048);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] rand_speed();
      case ($urandom_range(0, 7))
         0: return 24'h0;
         1: return 24'hFF_FFFF;
         2, 3: return 24'($urandom_range(0, 24'hFFFF));
         default: return 24'($urandom);
      endcase
   endfunction

   // coordinate landing in cell idx for a given reciprocal spacing
   function automatic logic [31:0] aim(int idx, logic [31:0] inv);
      logic [63:0] t;
      t = {32'(idx), 32'($urandom)} / 64'(inv);
      return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
   endfunction

   function automatic int pick_cell(int n);
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(0, n - 2);
      if (r < 94) return n - 1;
      return n;
   endfunction

   // ------------------------------------------------------------------
   // stimulus side
   // ------------------------------------------------------------------
   task automatic send_word(word_type w, bit fixed = 0, speeds_type val = '{0, 0, 0});
      typed_type t;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= w.op;
      req_tdata  <= {1'b0, w.pressure, w.shear, w.pz, w.py, w.px, w.factor, w.addr};
      t.fixed = fixed; t.val = val;
      typed_q.insert(typed_q.size(), t);
      if (w.op == tfvs_pkg::OP_LOAD) grid_loaded[w.addr] = 1;
      words_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_load(int addr, logic [15:0] f);
      word_type w;
      w = '{tfvs_pkg::OP_LOAD, 15'(addr), f, 32'($urandom), 32'($urandom), 32'($urandom),
            24'($urandom), 24'($urandom)};
      send_word(w);
   endtask

   // load what the point needs, sometimes refresh, then send it
   task automatic send_point(word_type w, bit refresh);
      int q [$];
      words_read(w, q);
      foreach (q[n])
         if (!grid_loaded[q[n]] || (refresh && $urandom_range(0, 2) == 0))
            send_load(q[n], rand_factor());
      send_word(w);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (speeds_q.size() != 0 || typed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] v);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 1'b0;
      apply_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic set_phase_regs(int p);
      logic [31:0] v [8];
      logic [31:0] a;
      case (p)
         0: v = '{32'h0100_0000, 32'h0100_0000, 0, 32'hFFFF_FFFF, 32'hFF_FFFF, 32, 32, 32};
         1: v = '{32'h0040_0000, 32'h0200_0000, 32'h100, 32'h0020_0000, 32'h80_0000, 16, 8, 4};
         2: v = '{32'hFFFF_FFFF, 1, 0, 32'hFFFF_FFFF, 0, 0, 1, 63};
         4: v = '{1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFF_FFFF, 2, 2, 2};
         default: begin
            a = $urandom_range(0, 32'h1000);
            v[0] = ($urandom_range(0, 3) == 0) ? ($urandom | 1) :
                   $urandom_range(32'h0010_0000, 32'h0400_0000);
            v[1] = $urandom_range(32'h0010_0000, 32'h0400_0000);
            v[2] = a;
            v[3] = a + $urandom_range(32'h100, 32'h0010_0000);
            v[4] = $urandom_range(0, 24'hFF_FFFF);
            v[5] = $urandom_range(0, 63);
            v[6] = $urandom_range(0, 63);
            v[7] = $urandom_range(0, 63);
         end
      endcase
      for (int i = 0; i < 8; i++) write_reg(IDX_W'(i), v[i]);
   endtask

   task automatic random_word();
      word_type w;
      logic [32:0] zsum;
      int r;
      r = $urandom_range(0, 99);
      if (r >= 70 && r < 85) begin
         send_load($urandom_range(0, 32767), rand_factor());
         return;
      end
      w.op = tfvs_pkg::OP_POINT; w.addr = 15'($urandom); w.factor = 16'($urandom);
      w.shear = rand_speed(); w.pressure = rand_speed();
      if (r < 70) begin
         w.px = aim(pick_cell(clamp_cnt(cnt_x, 32)), inv_h);
         w.py = aim(pick_cell(clamp_cnt(cnt_y, 32)), inv_h);
         zsum = 33'(band_lo) + 33'(aim(pick_cell(clamp_cnt(cnt_z, 32)), inv_v));
         w.pz = zsum[32] ? 32'hFFFF_FFFF : zsum[31:0];
         if ($urandom_range(0, 9) == 0)
            w.shear = 24'(shear_limit + 24'($urandom_range(0, 1)));
      end else begin
         w.px = $urandom; w.py = $urandom; w.pz = $urandom;
      end
      send_point(w, r < 70);
   endtask

   function automatic word_type pt(logic [31:0] x, y, z, logic [23:0] s, p);
      return '{tfvs_pkg::OP_POINT, 15'd0, 16'd0, x, y, z, s, p};
   endfunction

   function automatic void add_word(word_type w, bit fixed = 0,
                                    speeds_type val = '{0, 0, 0});
      rows.insert(rows.size(), '{ROW_WORD, w, tfvs_pkg::REG_INV_HORIZ, 32'd0, fixed, val});
   endfunction

   function automatic void add_load(int addr, logic [15:0] f);
      add_word('{tfvs_pkg::OP_LOAD, 15'(addr), f, 0, 0, 0, 0, 0}, 1,
               '{0, 0, tfvs_pkg::OUT_LOADED});
   endfunction

   function automatic void add_csr(logic [IDX_W-1:0] idx, logic [31:0] v);
      rows.insert(rows.size(), '{ROW_CSR, pt(0, 0, 0, 0, 0), idx, v, 0, '{0, 0, 0}});
   endfunction

   // directed table, registers at reset values (one metre per cell)
   function automatic void build_table();
      add_load(0, 16'h4000);     add_load(1, 16'h7FFF);
      add_load(32, 16'h8000);    add_load(33, 16'h4000);
      add_load(1024, 16'h2000);  add_load(1025, 16'h4000);
      add_load(1056, 16'h0000);  add_load(1057, 16'h4000);
      add_load(31, 16'h7FFF);    add_load(32767, 16'h8000);
      // cell origin, then cell center
      add_word(pt(0, 0, 0, 24'h12_3456, 24'hFF_FFFF));
      add_word(pt(32'h80, 32'h80, 32'h80, 24'hAB_CDEF, 24'h00_0001));
      // top edge, factor near two saturates
      add_word(pt(32'h1F00, 0, 0, 24'hFF_FFFF, 24'h40_0000));
      // far corner, most negative factor gives zero
      add_word(pt(32'h1F00, 32'h1F00, 32'h1F00, 24'h00_ABCD, 24'h00_F00D), 1,
               '{0, 0, tfvs_pkg::OUT_EDGE});
      // off the grid along x and along z
      add_word(pt(32'hFFFF_FFFF, 0, 0, 24'h11_1111, 24'h22_2222), 1,
               '{24'h11_1111, 24'h22_2222, tfvs_pkg::OUT_OFFGRID});
      add_word(pt(0, 0, 32'h2000, 24'h33_3333, 24'h44_4444), 1,
               '{24'h33_3333, 24'h44_4444, tfvs_pkg::OUT_OFFGRID});
      // above and below the depth band
      add_csr(tfvs_pkg::REG_BAND_LOW, 32'h100);
      add_word(pt(0, 0, 0, 24'h55_5555, 24'h66_6666), 1,
               '{24'h55_5555, 24'h66_6666, tfvs_pkg::OUT_OUTSIDE});
      add_csr(tfvs_pkg::REG_BAND_HIGH, 32'h200);
      add_word(pt(0, 0, 32'h201, 24'h77_7777, 24'h88_8888), 1,
               '{24'h77_7777, 24'h88_8888, tfvs_pkg::OUT_OUTSIDE});
      // shear limit, just above and exactly on it
      add_csr(tfvs_pkg::REG_SHEAR_LIMIT, 32'h1000);
      add_word(pt(0, 0, 32'h100, 24'h00_1001, 24'h99_9999), 1,
               '{24'h00_1001, 24'h99_9999, tfvs_pkg::OUT_ABOVE});
      add_word(pt(0, 0, 32'h100, 24'h00_1000, 24'h99_9999));
      add_csr(tfvs_pkg::REG_SHEAR_LIMIT, 32'hFF_FFFF);
      add_csr(tfvs_pkg::REG_BAND_HIGH, 32'hFFFF_FFFF);
      add_csr(tfvs_pkg::REG_BAND_LOW, 32'h0);
   endfunction

   initial begin
      build_table();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // walk the directed table; drain before every register write
      foreach (rows[n]) begin
         if (rows[n].kind == ROW_CSR) begin
            drain();
            write_reg(rows[n].idx, rows[n].data);
         end else begin
            send_word(rows[n].w, rows[n].fixed, rows[n].val);
         end
      end
      // random phases: registers change while idle, idle pattern rotates
      for (int p = 0; p < 6; p++) begin
         drain();
         set_phase_regs(p);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         if (p == 4) hold_request = 1;
         for (int k = words_sent + PHASE_WORDS; words_sent < k; ) random_word();
      end
      drain();
      if (mismatches == 0 && speeds_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 0;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // predict on every accepted input word
   always @(posedge clock) begin
      typed_type  t;
      speeds_type r;
      word_type   w;
      if (!reset && req_tvalid && req_tready) begin
         w.op = req_tuser[0];
         {w.pressure, w.shear, w.pz, w.py, w.px, w.factor, w.addr} = req_tdata[174:0];
         r = predict_speeds(w);
         t = typed_q.pop_front();
         speeds_q.insert(speeds_q.size(), t.fixed ? t.val : r);
      end
   end

   // compare every accepted result word with the oldest expectation
   always @(posedge clock) begin
      speeds_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (speeds_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result word: shear %h pressure %h outcome %0d",
                        rsp_tdata[23:0], rsp_tdata[47:24], rsp_tuser);
         end else begin
            e = speeds_q.pop_front();
            if (e.shear !== rsp_tdata[23:0] || e.pressure !== rsp_tdata[47:24] ||
                e.outcome !== rsp_tuser) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("result mismatch: expected %h/%h/%0d got %h/%h/%0d",
                           e.shear, e.pressure, e.outcome,
                           rsp_tdata[23:0], rsp_tdata[47:24], rsp_tuser);
            end
         end
      end
   end

   // watchdog: stop when nothing moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stuck = 0;
         else stuck++;
         if (stuck >= STUCK_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

endmodule

/* trilinear_field_velocity_scaler.f */
rtl/core/tfvs_pkg.sv
rtl/core/trilinear_field_velocity_scaler.sv
sim/trilinear_field_velocity_scaler_tb.sv
